[rtl/lcb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcb_pkg
// Shared types and codes of the LRU cache with byte budget.
// ----------------------------------------------------------------------------
package lcb_pkg;

  typedef enum logic [1:0] {
    OP_GET        = 2'd0,
    OP_PUT        = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_CLEAR      = 2'd3
  } lcb_op_t;

  typedef enum logic [2:0] {
    STAT_MISS        = 3'd0,
    STAT_HIT         = 3'd1,
    STAT_STALE       = 3'd2,
    STAT_STORED      = 3'd3,
    STAT_REJECTED    = 3'd4,
    STAT_INVALIDATED = 3'd5,
    STAT_CLEARED     = 3'd6
  } lcb_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_PROMOTE,
    S_REMOVE,
    S_ECHECK,
    S_EVICT,
    S_INSERT,
    S_WRITE,
    S_OUT
  } lcb_state_t;

  localparam logic [1:0] CFG_MAX_ENTRIES     = 2'd0;
  localparam logic [1:0] CFG_MAX_TOTAL_BYTES = 2'd1;
  localparam logic [1:0] CFG_MAX_FILE_SIZE   = 2'd2;

  localparam logic [4:0]  RST_MAX_ENTRIES     = 5'd16;
  localparam logic [39:0] RST_MAX_TOTAL_BYTES = 40'd16777216;
  localparam logic [31:0] RST_MAX_FILE_SIZE   = 32'd1048576;

endpackage
`default_nettype wire

[rtl/lcb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcb_if
// Request and result channels of the LRU cache with byte budget.
// ----------------------------------------------------------------------------
interface lcb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key_tag;
  logic [39:0] mod_time;
  logic [31:0] file_size;

  modport source (output valid, opcode, key_tag, mod_time, file_size, input ready);
  modport sink (input valid, opcode, key_tag, mod_time, file_size, output ready);
endinterface

interface lcb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [4:0]  evicted_count;
  logic [4:0]  entries_in_use;
  logic [39:0] bytes_in_use;

  modport source (output valid, status, slot, evicted_count, entries_in_use,
                  bytes_in_use, input ready);
  modport sink (input valid, status, slot, evicted_count, entries_in_use,
                bytes_in_use, output ready);
endinterface
`default_nettype wire

[rtl/lru_cache_with_byte_budget.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_cache_with_byte_budget
// Fully associative metadata cache with LRU replacement under an entry
// limit and a byte budget.
// ----------------------------------------------------------------------------
// Usage: one request beat enters on in_bus (get, put, invalidate or clear)
// and exactly one result beat leaves on out_bus. The three limits are to be
// written through the APB-style cfg_ port only while the block is idle; the
// block itself does not enforce this. The block works on one request at a
// time. Entry records (key, time, size, recency rank) live in one
// synchronous memory; most steps are sweeps over that memory, whose single
// read port delivers one entry per cycle. A get or invalidate that finds
// its key takes two sweeps, and a miss or a rejected put takes one; a
// stored put takes a search sweep, an optional removal sweep, one sweep plus
// one check state per evicted entry, one more check state and an insert
// sweep plus a write state. A clear has its result ready the cycle after it
// is accepted.
// Reset clears the valid bits and counters and loads the reset limits at
// once; no clearing pass is needed. The result sits in an output register
// until taken; while the receiver stalls, no new request is accepted.
// ----------------------------------------------------------------------------
module lru_cache_with_byte_budget
  import lcb_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lcb_in_if.sink           in_bus,
  lcb_out_if.source        out_bus,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  typedef struct packed {
    logic [63:0]   key;
    logic [39:0]   mtime;
    logic [31:0]   nbytes;
    logic [RW-1:0] rank;
  } ent_t;

  // Configuration registers.
  logic [4:0]  max_entries_r;
  logic [39:0] max_total_bytes_r;
  logic [31:0] max_file_size_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r     <= RST_MAX_ENTRIES;
      max_total_bytes_r <= RST_MAX_TOTAL_BYTES;
      max_file_size_r   <= RST_MAX_FILE_SIZE;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        CFG_MAX_ENTRIES:     max_entries_r     <= cfg_pwdata[4:0];
        CFG_MAX_TOTAL_BYTES: max_total_bytes_r <= cfg_pwdata[39:0];
        CFG_MAX_FILE_SIZE:   max_file_size_r   <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      CFG_MAX_ENTRIES:     cfg_prdata = 64'(max_entries_r);
      CFG_MAX_TOTAL_BYTES: cfg_prdata = 64'(max_total_bytes_r);
      CFG_MAX_FILE_SIZE:   cfg_prdata = 64'(max_file_size_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Control and request state.
  lcb_state_t        state_r, state_nxt;
  lcb_status_t       stat_r, stat_nxt;
  lcb_op_t           op_r;
  logic [63:0]       key_r;
  logic [39:0]       time_r;
  logic [31:0]       size_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CW-1:0]     count_r;
  logic [39:0]       sum_r;
  logic [CW-1:0]     evict_cnt_r;

  // Sweep sequencer: idx_r issues reads, pv_r/pidx_r mark returning data.
  logic [CW-1:0]     idx_r;
  logic              pv_r;
  logic [RW-1:0]     pidx_r;
  logic              sweep_end;
  logic              in_sweep;

  // Search and sweep results.
  logic              found_r;
  logic              tok_r;
  logic [RW-1:0]     slot_r;
  logic [RW-1:0]     srank_r;
  logic [31:0]       sbytes_r;
  logic              got_r;
  logic              free_found_r;
  logic [RW-1:0]     free_r;

  // Entry memory.
  ent_t              mem [ENTRIES];
  ent_t              rd_data_r;
  logic              wr_en;
  logic [RW-1:0]     wr_addr;
  ent_t              wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[idx_r[RW-1:0]];
  end

  logic          in_acc;
  logic          out_acc;
  logic          cur_v;
  logic          hit_now;
  logic          f_all;
  logic          tok_all;
  logic [LW-1:0] limit;
  logic          need_evict;
  logic [40:0]   sum_plus;
  logic          evict_hit;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_acc  = out_bus.valid && out_bus.ready;
  assign in_sweep = (state_r == S_SEARCH) || (state_r == S_PROMOTE) ||
                    (state_r == S_REMOVE) || (state_r == S_EVICT) ||
                    (state_r == S_INSERT);
  assign sweep_end = pv_r && (pidx_r == RW'(ENTRIES - 1));
  assign cur_v     = valid_r[pidx_r];
  assign hit_now   = (state_r == S_SEARCH) && pv_r && cur_v && !found_r &&
                     (rd_data_r.key == key_r);
  assign f_all     = found_r || hit_now;
  assign tok_all   = found_r ? tok_r : (rd_data_r.mtime == time_r);
  assign evict_hit = (state_r == S_EVICT) && pv_r && cur_v && !got_r &&
                     (rd_data_r.rank == RW'(count_r - CW'(1)));

  // The count limit saturates at the number of slots.
  assign limit = (LW'(max_entries_r) > LW'(ENTRIES)) ? LW'(ENTRIES) : LW'(max_entries_r);
  assign sum_plus   = {1'b0, sum_r} + 41'(size_r);
  assign need_evict = (count_r != '0) &&
                      ((LW'(count_r) >= limit) || (sum_plus > 41'(max_total_bytes_r)));

  // Rank updates write back the entry just read; the new item is written
  // in its own write state after the insert sweep.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pidx_r;
    wr_data = rd_data_r;
    case (state_r)
      S_PROMOTE: begin
        if (pv_r && pidx_r == slot_r) begin
          wr_en        = 1'b1;
          wr_data.rank = '0;
        end else if (pv_r && cur_v && rd_data_r.rank < srank_r) begin
          wr_en        = 1'b1;
          wr_data.rank = rd_data_r.rank + RW'(1);
        end
      end
      S_REMOVE: begin
        if (pv_r && cur_v && rd_data_r.rank > srank_r) begin
          wr_en        = 1'b1;
          wr_data.rank = rd_data_r.rank - RW'(1);
        end
      end
      S_INSERT: begin
        if (pv_r && cur_v) begin
          wr_en        = 1'b1;
          wr_data.rank = rd_data_r.rank + RW'(1);
        end
      end
      S_WRITE: begin
        wr_en          = 1'b1;
        wr_addr        = free_r;
        wr_data.key    = key_r;
        wr_data.mtime  = time_r;
        wr_data.nbytes = size_r;
        wr_data.rank   = '0;
      end
      default: ;
    endcase
  end

  // Next state and result status.
  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (lcb_op_t'(in_bus.opcode) == OP_CLEAR) begin
            state_nxt = S_OUT;
            stat_nxt  = STAT_CLEARED;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (sweep_end) begin
          case (op_r)
            OP_GET: begin
              if (!f_all) begin
                state_nxt = S_OUT;
                stat_nxt  = STAT_MISS;
              end else if (tok_all) begin
                state_nxt = S_PROMOTE;
                stat_nxt  = STAT_HIT;
              end else begin
                state_nxt = S_REMOVE;
                stat_nxt  = STAT_STALE;
              end
            end
            OP_PUT: begin
              if (size_r > max_file_size_r) begin
                state_nxt = S_OUT;
                stat_nxt  = STAT_REJECTED;
              end else begin
                state_nxt = f_all ? S_REMOVE : S_ECHECK;
                stat_nxt  = STAT_STORED;
              end
            end
            default: begin
              state_nxt = f_all ? S_REMOVE : S_OUT;
              stat_nxt  = f_all ? STAT_INVALIDATED : STAT_MISS;
            end
          endcase
        end
      end
      S_PROMOTE: if (sweep_end) state_nxt = S_OUT;
      S_REMOVE:  if (sweep_end) state_nxt = (op_r == OP_PUT) ? S_ECHECK : S_OUT;
      S_ECHECK:  state_nxt = need_evict ? S_EVICT : S_INSERT;
      S_EVICT:   if (sweep_end) state_nxt = S_ECHECK;
      S_INSERT:  if (sweep_end) state_nxt = S_WRITE;
      S_WRITE:   state_nxt = S_OUT;
      S_OUT:     if (out_acc) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= STAT_MISS;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

  // Sweep sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      pv_r  <= 1'b0;
    end else if (in_sweep && state_nxt == state_r) begin
      pv_r <= (idx_r < CW'(ENTRIES));
      if (idx_r < CW'(ENTRIES)) begin
        idx_r <= idx_r + CW'(1);
      end
    end else begin
      idx_r <= '0;
      pv_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= idx_r[RW-1:0];
  end

  // Valid bits, occupancy and byte total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      evict_cnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            evict_cnt_r <= '0;
            if (lcb_op_t'(in_bus.opcode) == OP_CLEAR) begin
              valid_r <= '0;
              count_r <= '0;
              sum_r   <= '0;
            end
          end
        end
        S_REMOVE: begin
          if (sweep_end) begin
            valid_r[slot_r] <= 1'b0;
            count_r         <= count_r - CW'(1);
            sum_r           <= sum_r - 40'(sbytes_r);
          end
        end
        S_EVICT: begin
          if (evict_hit) begin
            valid_r[pidx_r] <= 1'b0;
            count_r         <= count_r - CW'(1);
            sum_r           <= sum_r - 40'(rd_data_r.nbytes);
            evict_cnt_r     <= evict_cnt_r + CW'(1);
          end
        end
        S_WRITE: begin
          valid_r[free_r] <= 1'b1;
          count_r         <= count_r + CW'(1);
          sum_r           <= sum_plus[39:0];
        end
        default: ;
      endcase
    end
  end

  // Request payload and sweep results.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      op_r         <= lcb_op_t'(in_bus.opcode);
      key_r        <= in_bus.key_tag;
      time_r       <= in_bus.mod_time;
      size_r       <= in_bus.file_size;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      free_r       <= '0;
    end
    if (hit_now) begin
      found_r  <= 1'b1;
      tok_r    <= (rd_data_r.mtime == time_r);
      slot_r   <= pidx_r;
      srank_r  <= rd_data_r.rank;
      sbytes_r <= rd_data_r.nbytes;
    end
    if (state_r == S_ECHECK) begin
      got_r <= 1'b0;
    end else if (evict_hit) begin
      got_r <= 1'b1;
    end
    if (state_r == S_INSERT && pv_r && !cur_v && !free_found_r) begin
      free_found_r <= 1'b1;
      free_r       <= pidx_r;
    end
  end

  // Handshake and result beat.
  assign in_bus.ready          = (state_r == S_IDLE);
  assign out_bus.valid         = (state_r == S_OUT);
  assign out_bus.status        = stat_r;
  assign out_bus.slot          = (stat_r == STAT_HIT)    ? 4'(slot_r) :
                                 (stat_r == STAT_STORED) ? 4'(free_r) : 4'd0;
  assign out_bus.evicted_count = 5'(evict_cnt_r);
  assign out_bus.entries_in_use = 5'(count_r);
  assign out_bus.bytes_in_use  = sum_r;

endmodule
`default_nettype wire

[rtl/lcb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcb_checker
// Port-level checks of the LRU cache with byte budget.
// ----------------------------------------------------------------------------
module lcb_checker
  import lcb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [3:0]  out_slot,
  input wire logic [4:0]  out_evicted,
  input wire logic [4:0]  out_entries,
  input wire logic [39:0] out_bytes
);

  // A request is never taken while a result is pending.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  // Right after a request is taken, the block is busy and takes no other.
  a_accept_then_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid || !out_valid && !in_ready)
    else $error("block ready again right after accepting a request");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_CLEARED) |->
      (out_entries == 5'd0 && out_bytes == 40'd0 && out_slot == 4'd0))
    else $error("clear left entries behind");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_REJECTED) |->
      (out_slot == 4'd0 && out_evicted == 5'd0))
    else $error("rejected put reported a slot or evictions");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_bytes)))
    else $error("stalled result changed");

endmodule

bind lru_cache_with_byte_budget lcb_checker u_lcb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_status  (out_bus.status),
  .out_slot    (out_bus.slot),
  .out_evicted (out_bus.evicted_count),
  .out_entries (out_bus.entries_in_use),
  .out_bytes   (out_bus.bytes_in_use)
);
`default_nettype wire

[tb/sv/lru_cache_with_byte_budget_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_with_byte_budget_tb
// Self-checking bench for the LRU metadata cache with a byte budget. A
// directed table covers reset behavior, limits and every opcode, then random
// request streams over a small key pool run against a behavioral cache
// model through several limit settings and idling phases.
// ----------------------------------------------------------------------------
module lru_cache_with_byte_budget_tb
  import lcb_pkg::*;
;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  lcb_in_if in_bus ();
  lcb_out_if out_bus ();

  lru_cache_with_byte_budget dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    lcb_op_t     op;
    logic [63:0] key;
    logic [39:0] mtime;
    logic [31:0] size;
  } request_t;

  typedef struct packed {
    lcb_status_t status;
    logic [3:0]  slot;
    logic [4:0]  evicted;
    logic [4:0]  entries;
    logic [39:0] bytes;
  } result_t;

  // One row of the directed table. When has_fixed is set, the typed-in
  // result must also agree with the cache model, which catches a slip in
  // the table as well as a fault in the block.
  typedef struct {
    request_t req;
    bit       has_fixed;
    result_t  fixed;
  } row_t;

  // Cache model state and the limits it works under.
  logic [4:0]  lim_entries;
  logic [39:0] lim_bytes;
  logic [31:0] lim_size;
  bit          c_valid [NSLOT];
  logic [63:0] c_key   [NSLOT];
  logic [39:0] c_time  [NSLOT];
  logic [31:0] c_bytes [NSLOT];
  int          c_rank  [NSLOT];
  int          c_count;
  logic [39:0] c_sum;

  result_t pending_results[$];
  int errors = 0;
  int beats_out = 0;
  int beats_in = 0;
  int cycles = 0;

  // Idling controls: percent chance of an idle cycle on each side, plus a
  // long receiver hold-off counted down in the monitor process.
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_cycles = 0;

  function automatic int lookup(logic [63:0] key);
    for (int i = 0; i < NSLOT; i++)
      if (c_valid[i] && c_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    for (int i = 0; i < NSLOT; i++)
      if (c_valid[i] && c_rank[i] > c_rank[s]) c_rank[i]--;
    c_valid[s] = 1'b0;
    c_sum -= 40'(c_bytes[s]);
    c_count--;
  endfunction

  function automatic result_t cache_predict(request_t r);
    result_t res;
    int s;
    int lim;
    res = '{STAT_MISS, 4'd0, 5'd0, 5'd0, 40'd0};
    case (r.op)
      OP_GET: begin
        s = lookup(r.key);
        if (s >= 0) begin
          if (c_time[s] != r.mtime) begin
            drop_slot(s);
            res.status = STAT_STALE;
          end else begin
            for (int i = 0; i < NSLOT; i++)
              if (c_valid[i] && c_rank[i] < c_rank[s]) c_rank[i]++;
            c_rank[s] = 0;
            res.status = STAT_HIT;
            res.slot = 4'(s);
          end
        end
      end
      OP_PUT: begin
        if (r.size > lim_size) begin
          res.status = STAT_REJECTED;
        end else begin
          lim = (lim_entries > NSLOT) ? NSLOT : int'(lim_entries);
          s = lookup(r.key);
          if (s >= 0) drop_slot(s);
          // Evict from the old end until both the count and byte limits fit.
          while (c_count > 0 && (c_count >= lim ||
                 {1'b0, c_sum} + 41'(r.size) > {1'b0, lim_bytes})) begin
            for (int i = 0; i < NSLOT; i++)
              if (c_valid[i] && c_rank[i] == c_count - 1) begin
                drop_slot(i);
                break;
              end
            res.evicted++;
          end
          s = 0;
          for (int i = NSLOT - 1; i >= 0; i--)
            if (!c_valid[i]) s = i;
          for (int i = 0; i < NSLOT; i++)
            if (c_valid[i]) c_rank[i]++;
          c_valid[s] = 1'b1;
          c_key[s] = r.key;
          c_time[s] = r.mtime;
          c_bytes[s] = r.size;
          c_rank[s] = 0;
          c_count++;
          c_sum += 40'(r.size);
          res.status = STAT_STORED;
          res.slot = 4'(s);
        end
      end
      OP_INVALIDATE: begin
        s = lookup(r.key);
        if (s >= 0) begin
          drop_slot(s);
          res.status = STAT_INVALIDATED;
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) c_valid[i] = 1'b0;
        c_count = 0;
        c_sum = '0;
        res.status = STAT_CLEARED;
      end
    endcase
    res.entries = 5'(c_count);
    res.bytes = c_sum;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH beat %0d %s: got %0h expected %0h", beats_out, what, got, want);
  endtask

  // Sender: offers one request and holds it until the block takes it. Valid
  // stays up after the beat so the next request can follow at once; drain
  // drops it.
  task automatic send_request(request_t r);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.opcode <= r.op;
    in_bus.key_tag <= r.key;
    in_bus.mod_time <= r.mtime;
    in_bus.file_size <= r.size;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(cache_predict(r));
    beats_in++;
    @(negedge clk);
  endtask

  // Waits until every expected result has arrived, then lets the block
  // settle so a configuration write lands while it is idle.
  task automatic drain;
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'({idx, 3'b000});
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      CFG_MAX_ENTRIES:     lim_entries = value[4:0];
      CFG_MAX_TOTAL_BYTES: lim_bytes = value[39:0];
      default:             lim_size = value[31:0];
    endcase
    @(negedge clk);
  endtask

  task automatic set_limits(logic [4:0] e, logic [39:0] b, logic [31:0] f);
    write_limit(CFG_MAX_ENTRIES, 64'(e));
    write_limit(CFG_MAX_TOTAL_BYTES, 64'(b));
    write_limit(CFG_MAX_FILE_SIZE, 64'(f));
  endtask

  // Monitor: receiver stalls at random or for a long hold-off, and each
  // accepted result beat is compared with the oldest expectation.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_bus.status), 64'hx);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.status != want.status)
          report_mismatch("status", 64'(out_bus.status), 64'(want.status));
        if (out_bus.slot != want.slot)
          report_mismatch("slot", 64'(out_bus.slot), 64'(want.slot));
        if (out_bus.evicted_count != want.evicted)
          report_mismatch("evicted_count", 64'(out_bus.evicted_count), 64'(want.evicted));
        if (out_bus.entries_in_use != want.entries)
          report_mismatch("entries_in_use", 64'(out_bus.entries_in_use), 64'(want.entries));
        if (out_bus.bytes_in_use != want.bytes)
          report_mismatch("bytes_in_use", 64'(out_bus.bytes_in_use), 64'(want.bytes));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Random request. Keys come from a small pool so gets and puts collide;
  // times come from a few values so both fresh and stale gets occur. A
  // rare wide key or time keeps every bit of those fields toggling.
  function automatic request_t random_request(int keypool, logic [31:0] size_cap);
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r.op = (pick < 35) ? OP_GET : (pick < 80) ? OP_PUT : (pick < 97) ? OP_INVALIDATE
                                                                     : OP_CLEAR;
    r.key = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                      : 64'($urandom_range(keypool - 1)) ^ 64'hA5A5_0000_0000_5A5A;
    r.mtime = ($urandom_range(19) == 0) ? {8'($urandom), $urandom}
                                        : 40'($urandom_range(2));
    case ($urandom_range(9))
      0:       r.size = $urandom;
      1:       r.size = size_cap;
      default: r.size = 32'($urandom_range(size_cap));
    endcase
    return r;
  endfunction

  task automatic random_phase(int count, int keypool, logic [31:0] size_cap);
    for (int i = 0; i < count; i++) send_request(random_request(keypool, size_cap));
  endtask

  localparam logic [63:0] KA = 64'h0;
  localparam logic [63:0] KB = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KC = 64'h0123_4567_89AB_CDEF;
  localparam logic [39:0] TMAX = 40'hFF_FFFF_FFFF;

  row_t directed[$];

  function automatic row_t row(lcb_op_t op, logic [63:0] k, logic [39:0] t, logic [31:0] s,
                               bit fixed_on, result_t fx);
    row_t x;
    x.req = '{op, k, t, s};
    x.has_fixed = fixed_on;
    x.fixed = fx;
    return x;
  endfunction

  initial begin
    result_t got;
    result_t none;
    none = '{STAT_MISS, 4'd0, 5'd0, 5'd0, 40'd0};
    in_bus.valid = 1'b0;
    in_bus.opcode = OP_GET;
    in_bus.key_tag = '0;
    in_bus.mod_time = '0;
    in_bus.file_size = '0;
    lim_entries = RST_MAX_ENTRIES;
    lim_bytes = RST_MAX_TOTAL_BYTES;
    lim_size = RST_MAX_FILE_SIZE;
    for (int i = 0; i < NSLOT; i++) begin
      c_valid[i] = 1'b0;
      c_rank[i] = 0;
    end
    c_count = 0;
    c_sum = '0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset limits: empty-cache misses, the size
    // limit at and just past its edge, stale and fresh gets, replacement
    // of a held key, invalidate hit and miss, eviction at the entry limit, and clear.
    directed.push_back(row(OP_GET, KA, 40'd0, 32'd0, 1'b1, none));
    directed.push_back(row(OP_INVALIDATE, KB, TMAX, 32'd0, 1'b1, none));
    directed.push_back(row(OP_PUT, KA, 40'd0, RST_MAX_FILE_SIZE + 32'd1, 1'b1,
                           '{STAT_REJECTED, 4'd0, 5'd0, 5'd0, 40'd0}));
    directed.push_back(row(OP_PUT, KA, 40'd0, 32'hFFFF_FFFF, 1'b1,
                           '{STAT_REJECTED, 4'd0, 5'd0, 5'd0, 40'd0}));
    directed.push_back(row(OP_PUT, KA, 40'd0, RST_MAX_FILE_SIZE, 1'b1,
                           '{STAT_STORED, 4'd0, 5'd0, 5'd1, 40'(RST_MAX_FILE_SIZE)}));
    directed.push_back(row(OP_PUT, KB, TMAX, 32'd0, 1'b1,
                           '{STAT_STORED, 4'd1, 5'd0, 5'd2, 40'(RST_MAX_FILE_SIZE)}));
    directed.push_back(row(OP_GET, KB, TMAX, 32'd0, 1'b1,
                           '{STAT_HIT, 4'd1, 5'd0, 5'd2, 40'(RST_MAX_FILE_SIZE)}));
    directed.push_back(row(OP_GET, KA, 40'd1, 32'd0, 1'b1,
                           '{STAT_STALE, 4'd0, 5'd0, 5'd1, 40'd0}));
    directed.push_back(row(OP_PUT, KC, 40'd7, 32'd100, 1'b0, none));
    directed.push_back(row(OP_PUT, KC, 40'd8, 32'd200, 1'b0, none));
    directed.push_back(row(OP_GET, KC, 40'd8, 32'd0, 1'b0, none));
    directed.push_back(row(OP_INVALIDATE, KC, 40'd0, 32'd0, 1'b0, none));
    directed.push_back(row(OP_INVALIDATE, KC, 40'd0, 32'd0, 1'b0, none));
    for (int i = 0; i < 17; i++)
      directed.push_back(row(OP_PUT, 64'(i + 16), 40'(i), 32'(i), 1'b0, none));
    directed.push_back(row(OP_CLEAR, KA, 40'd0, 32'd0, 1'b1,
                           '{STAT_CLEARED, 4'd0, 5'd0, 5'd0, 40'd0}));

    foreach (directed[i]) begin
      if (directed[i].has_fixed) begin
        got = directed[i].fixed;
        // Cross-check the typed-in row against the cache model's view.
        send_request(directed[i].req);
        if (pending_results[$] != got)
          report_mismatch("directed table row", 64'(i), 64'(i));
      end else begin
        send_request(directed[i].req);
      end
    end
    drain();

    // Count limit of zero and item larger than the byte budget: both evict
    // everything and still insert the new item.
    set_limits(5'd0, 40'd50, 32'hFFFF_FFFF);
    send_request('{OP_PUT, KA, 40'd1, 32'd10});
    send_request('{OP_PUT, KB, 40'd2, 32'd10});
    drain();
    write_limit(CFG_MAX_ENTRIES, 64'd31);
    send_request('{OP_PUT, KC, 40'd3, 32'd20});
    send_request('{OP_PUT, KA, 40'd4, 32'hFFFF_FFFF});
    send_request('{OP_PUT, KB, 40'd5, 32'd0});
    drain();

    // Random phases, each with its own limits and idling mix.
    set_limits(5'd16, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(300, 24, 32'hFFFF_FFFF);
    drain();

    src_idle_pct = 46;
    set_limits(5'd4, 40'd1000, 32'd600);
    random_phase(300, 10, 32'd700);
    drain();

    src_idle_pct = 0;
    snk_stall_pct = 46;
    set_limits(5'd31, 40'd5000, 32'd2000);
    random_phase(300, 20, 32'd2100);
    drain();

    src_idle_pct = 29;
    snk_stall_pct = 29;
    set_limits(5'd1, 40'd0, 32'd3);
    random_phase(200, 6, 32'd4);
    drain();

    // Long receiver hold-off while the sender keeps offering requests, so
    // the block backs up and stalls its input.
    src_idle_pct = 0;
    snk_stall_pct = 0;
    set_limits(5'd8, 40'd4096, 32'd1024);
    hold_cycles = 400;
    random_phase(150, 12, 32'd1100);
    drain();

    src_idle_pct = 10;
    snk_stall_pct = 10;
    set_limits(5'd16, 40'd3000, 32'd800);
    random_phase(500, 18, 32'd900);
    drain();

    $display("Covered %0d requests and %0d results over six limit settings,", beats_in,
             beats_out);
    $display("with sender and receiver idling mixes and a long receiver hold-off.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
